>>> hdl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg: shared types and codes for the indexed min-heap queue
// Holds the payload structs, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package imhq_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_UPDATE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  handle;
    logic [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_handle;
    logic [31:0] out_key;
    logic [8:0]  entry_count;
    logic        is_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POSRD,
    S_POSWT,
    S_SWPRD,
    S_SWPWT,
    S_SWPWR,
    S_UPRD,
    S_UPWT,
    S_DNRD,
    S_DNWT,
    S_DNWT2,
    S_DONE
  } state_t;

endpackage

>>> hdl/indexed_min_heap_queue.sv
// Sequencing: a rejected item passes through S_DONE before out_valid rises; a sift up steps
// through S_UPRD and S_UPWT per level, a sift down through S_DNRD, S_DNWT and S_DNWT2.
// Handshake: one item at a time; in_ready is low from acceptance until the result is taken.
// Reset: rst_n synchronous active low clears the fill count and all presence bits.
// ----------------------------------------------------------------------------
// indexed_min_heap_queue: indexed binary min-heap priority queue
// Push, pop, remove and re-key of handles, sifted by one shared key comparator.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue #(
  parameter int CAPACITY     = 256,
  parameter int HANDLE_COUNT = 256,
  parameter int KEY_BITS     = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  imhq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output imhq_pkg::out_item_t out_data
);
  import imhq_pkg::*;

  localparam int PW = $clog2(CAPACITY + 1);   // position / count width
  localparam int AW = $clog2(CAPACITY + 1);   // slot address (1-based)
  localparam int HW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
  localparam int KW = KEY_BITS;

  // heap slot memory, position map and presence bits
  logic [KW-1:0] slot_key_m    [CAPACITY+1];
  logic [HW-1:0] slot_handle_m [CAPACITY+1];
  logic [PW-1:0] hpos_m        [HANDLE_COUNT];
  logic [HANDLE_COUNT-1:0] present_r, present_nxt;

  state_t state_r, state_nxt;
  logic [PW-1:0] fill_r, fill_nxt;
  logic [PW-1:0] pos_r, pos_nxt;       // current sift position
  logic [PW-1:0] oth_r, oth_nxt;       // partner position (swap / child)
  logic          down_r, down_nxt;     // sifting down after up
  logic [1:0]    kind_r, kind_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [KW-1:0] ka_r, ka_nxt;         // key at pos
  logic [HW-1:0] ha_r, ha_nxt;
  logic [KW-1:0] kb_r, kb_nxt;         // key at partner
  logic [HW-1:0] hb_r, hb_nxt;
  logic [1:0]    after_r, after_nxt;   // what follows a swap
  out_item_t     res_r, res_nxt;
  logic          ov_r, ov_nxt;

  localparam logic [1:0] AF_POPFIX = 2'd0, AF_RMFIX = 2'd1;

  // memory port control
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [KW-1:0] rd_key_q;
  logic [HW-1:0] rd_h_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] wr_key;
  logic [HW-1:0] wr_h;
  logic          pw_en;
  logic [HW-1:0] pw_h;
  logic [PW-1:0] pw_pos;
  logic          pr_en;
  logic [PW-1:0] pr_q;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_q <= slot_key_m[rd_addr];
      rd_h_q   <= slot_handle_m[rd_addr];
    end
    if (wr_en) begin
      slot_key_m[wr_addr]    <= wr_key;
      slot_handle_m[wr_addr] <= wr_h;
    end
  end

  always_ff @(posedge clk) begin
    if (pr_en) pr_q <= hpos_m[h_r];
    if (pw_en) hpos_m[pw_h] <= pw_pos;
  end

  // shared comparator: key b strictly below key a, operands picked by state
  logic [KW-1:0] cmp_a, cmp_b;
  logic          lt;
  always_comb begin
    cmp_a = ka_r; cmp_b = rd_key_q;
    if (state_r == S_UPWT) begin
      cmp_a = rd_key_q; cmp_b = ka_r;
    end else if (state_r == S_DNWT2) begin
      cmp_a = kb_r;
    end
  end
  assign lt = cmp_b < cmp_a;

  logic          h_ok;
  logic [HW-1:0] in_h;
  assign h_ok = {24'd0, in_data.handle} < 32'(HANDLE_COUNT);
  assign in_h = h_ok ? HW'(in_data.handle) : '0;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  // sequencer
  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; pos_nxt = pos_r; oth_nxt = oth_r;
    down_nxt = down_r; kind_nxt = kind_r; h_nxt = h_r; key_nxt = key_r;
    ka_nxt = ka_r; ha_nxt = ha_r; kb_nxt = kb_r; hb_nxt = hb_r;
    after_nxt = after_r; res_nxt = res_r; ov_nxt = ov_r;
    present_nxt = present_r;
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_key = '0; wr_h = '0;
    pw_en = 1'b0; pw_h = '0; pw_pos = '0; pr_en = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          kind_nxt = in_data.kind; h_nxt = in_h; key_nxt = KW'(in_data.key);
          res_nxt = '0; res_nxt.status = ST_OK; down_nxt = 1'b0;
          unique case (kind_t'(in_data.kind))
            KIND_PUSH: begin
              if (!h_ok) res_nxt.status = ST_ABSENT;
              else if (present_r[in_h]) res_nxt.status = ST_PRESENT;
              else if ({{(32-PW){1'b0}}, fill_r} >= 32'(CAPACITY)) res_nxt.status = ST_FULL;
              if (!h_ok || present_r[in_h]
                  || {{(32-PW){1'b0}}, fill_r} >= 32'(CAPACITY)) begin
                state_nxt = S_DONE;
              end else begin
                // append at the tail then sift up
                fill_nxt = fill_r + 1'b1;
                wr_en = 1'b1; wr_addr = AW'(fill_r + 1'b1);
                wr_key = KW'(in_data.key); wr_h = in_h;
                pw_en = 1'b1; pw_h = in_h; pw_pos = fill_r + 1'b1;
                present_nxt[in_h] = 1'b1;
                pos_nxt = fill_r + 1'b1;
                ka_nxt = KW'(in_data.key); ha_nxt = in_h;
                state_nxt = S_UPRD;
              end
            end
            KIND_POP: begin
              if (fill_r == '0) begin
                res_nxt.status = ST_EMPTY; state_nxt = S_DONE;
              end else begin
                pos_nxt = PW'(1); oth_nxt = fill_r;
                after_nxt = AF_POPFIX;
                rd_en = 1'b1; rd_addr = AW'(1);
                state_nxt = S_SWPRD;
              end
            end
            default: begin
              if (!h_ok || !present_r[in_h]) begin
                res_nxt.status = ST_ABSENT; state_nxt = S_DONE;
              end else begin
                state_nxt = S_POSRD;
              end
            end
          endcase
        end
      end
      S_POSRD: begin
        pr_en = 1'b1; state_nxt = S_POSWT;
      end
      S_POSWT: begin
        if (pr_q < PW'(1) || pr_q > fill_r) begin
          res_nxt.status = ST_ABSENT; state_nxt = S_DONE;
        end else if (kind_t'(kind_r) == KIND_REMOVE) begin
          pos_nxt = pr_q; oth_nxt = fill_r; after_nxt = AF_RMFIX;
          rd_en = 1'b1; rd_addr = AW'(pr_q);
          state_nxt = S_SWPRD;
        end else begin
          // rewrite key in place, then up and down
          pos_nxt = pr_q; down_nxt = 1'b1;
          wr_en = 1'b1; wr_addr = AW'(pr_q); wr_key = key_r; wr_h = h_r;
          ka_nxt = key_r; ha_nxt = h_r;
          state_nxt = S_UPRD;
        end
      end
      // swap pos with oth: pos data arrives here, read oth
      S_SWPRD: begin
        ka_nxt = rd_key_q; ha_nxt = rd_h_q;
        if (after_r == AF_POPFIX) begin
          res_nxt.out_handle = 8'(rd_h_q);
          res_nxt.out_key = 32'(rd_key_q);
        end
        rd_en = 1'b1; rd_addr = AW'(oth_r); state_nxt = S_SWPWT;
      end
      S_SWPWT: begin
        state_nxt = S_SWPWR;
      end
      S_SWPWR: begin
        // rd_key_q now holds oth; ka holds pos; write oth into pos
        wr_en = 1'b1; wr_addr = AW'(pos_r); wr_key = rd_key_q; wr_h = rd_h_q;
        pw_en = 1'b1; pw_h = rd_h_q; pw_pos = pos_r;
        kb_nxt = ka_r; hb_nxt = ha_r;
        ka_nxt = rd_key_q; ha_nxt = rd_h_q;
        fill_nxt = fill_r - 1'b1;
        present_nxt[ha_r] = 1'b0;
        if (after_r == AF_POPFIX) begin
          down_nxt = 1'b0; state_nxt = (fill_r > PW'(1)) ? S_DNRD : S_DONE;
        end else begin
          down_nxt = 1'b1;
          state_nxt = (pos_r < fill_r) ? S_UPRD : S_DONE;
        end
        if (!(pos_r < fill_r)) state_nxt = S_DONE;
      end
      // sift up: compare with parent
      S_UPRD: begin
        if (pos_r > PW'(1)) begin
          rd_en = 1'b1; rd_addr = AW'(pos_r >> 1); state_nxt = S_UPWT;
        end else begin
          // entry reached the root
          wr_en = 1'b1; wr_addr = AW'(pos_r); wr_key = ka_r; wr_h = ha_r;
          pw_en = 1'b1; pw_h = ha_r; pw_pos = pos_r;
          state_nxt = down_r ? S_DNRD : S_DONE;
        end
      end
      S_UPWT: begin
        if (lt) begin
          // parent moves down, entry moves up
          wr_en = 1'b1; wr_addr = AW'(pos_r); wr_key = rd_key_q; wr_h = rd_h_q;
          pw_en = 1'b1; pw_h = rd_h_q; pw_pos = pos_r;
          pos_nxt = pos_r >> 1;
          state_nxt = S_UPRD;
        end else begin
          // entry stops here
          wr_en = 1'b1; wr_addr = AW'(pos_r); wr_key = ka_r; wr_h = ha_r;
          pw_en = 1'b1; pw_h = ha_r; pw_pos = pos_r;
          state_nxt = down_r ? S_DNRD : S_DONE;
        end
      end
      // sift down: read left then right child
      S_DNRD: begin
        if ({1'b0, pos_r, 1'b0} <= {2'b0, fill_r}) begin
          rd_en = 1'b1; rd_addr = AW'({pos_r, 1'b0}); state_nxt = S_DNWT;
        end else begin
          wr_en = 1'b1; wr_addr = AW'(pos_r); wr_key = ka_r; wr_h = ha_r;
          pw_en = 1'b1; pw_h = ha_r; pw_pos = pos_r;
          state_nxt = S_DONE;
        end
      end
      S_DNWT: begin
        kb_nxt = ka_r; hb_nxt = ha_r; oth_nxt = pos_r;
        if (lt) begin
          kb_nxt = rd_key_q; hb_nxt = rd_h_q; oth_nxt = PW'({pos_r, 1'b0});
        end
        if ({1'b0, pos_r, 1'b1} <= {2'b0, fill_r}) begin
          rd_en = 1'b1; rd_addr = AW'({pos_r, 1'b1});
        end
        state_nxt = S_DNWT2;
      end
      S_DNWT2: begin
        if ({1'b0, pos_r, 1'b1} <= {2'b0, fill_r} && lt) begin
          wr_en = 1'b1; wr_addr = AW'(pos_r); wr_key = rd_key_q; wr_h = rd_h_q;
          pw_en = 1'b1; pw_h = rd_h_q; pw_pos = pos_r;
          pos_nxt = PW'({pos_r, 1'b1}); state_nxt = S_DNRD;
        end else if (oth_r != pos_r) begin
          wr_en = 1'b1; wr_addr = AW'(pos_r); wr_key = kb_r; wr_h = hb_r;
          pw_en = 1'b1; pw_h = hb_r; pw_pos = pos_r;
          pos_nxt = oth_r; state_nxt = S_DNRD;
        end else begin
          wr_en = 1'b1; wr_addr = AW'(pos_r); wr_key = ka_r; wr_h = ha_r;
          pw_en = 1'b1; pw_h = ha_r; pw_pos = pos_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_nxt.entry_count = 9'(fill_r);
        res_nxt.is_empty = (fill_r == '0);
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; fill_r <= '0; present_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; present_r <= present_nxt; ov_r <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt; oth_r <= oth_nxt; down_r <= down_nxt; kind_r <= kind_nxt;
    h_r <= h_nxt; key_r <= key_nxt; ka_r <= ka_nxt; ha_r <= ha_nxt;
    kb_r <= kb_nxt; hb_r <= hb_nxt; after_r <= after_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> tb/sv/imhq_checker.sv
// ----------------------------------------------------------------------------
// imhq_checker: result checker for the indexed min-heap queue
// Watches both channels, keeps its own heap image, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module imhq_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  imhq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  imhq_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count
);
  import imhq_pkg::*;

  localparam int CAP = 256;

  // shadow heap, 1-based
  logic [31:0] hp_key [0:CAP];
  logic [7:0]  hp_hdl [0:CAP];
  int          hdl_pos [0:255];
  bit          hdl_live [0:255];
  int          fill;

  out_item_t   heap_results [$];

  initial begin
    fail_count = 0;
    pending_count = 0;
    fill = 0;
    foreach (hdl_live[i]) hdl_live[i] = 0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic void swap_slots(input int a, input int b);
    logic [31:0] k;
    logic [7:0]  h;
    k = hp_key[a]; h = hp_hdl[a];
    hp_key[a] = hp_key[b]; hp_hdl[a] = hp_hdl[b];
    hp_key[b] = k; hp_hdl[b] = h;
    hdl_pos[hp_hdl[a]] = a;
    hdl_pos[hp_hdl[b]] = b;
  endfunction

  function automatic void sift_up(input int p);
    while (p > 1 && p <= fill && hp_key[p] < hp_key[p/2]) begin
      swap_slots(p, p/2);
      p = p / 2;
    end
  endfunction

  function automatic void sift_down(input int p);
    int best;
    while (p >= 1 && p <= fill) begin
      best = p;
      if (2*p <= fill && hp_key[2*p] < hp_key[best]) best = 2*p;
      if (2*p+1 <= fill && hp_key[2*p+1] < hp_key[best]) best = 2*p+1;
      if (best == p) break;
      swap_slots(p, best);
      p = best;
    end
  endfunction

  // apply one operation to the shadow heap and return its result
  function automatic out_item_t heap_apply(input in_item_t it);
    out_item_t r;
    int p;
    r = '0;
    r.status = ST_OK;
    case (kind_t'(it.kind))
      KIND_PUSH: begin
        if (hdl_live[it.handle]) r.status = ST_PRESENT;
        else if (fill >= CAP) r.status = ST_FULL;
        else begin
          fill++;
          hp_key[fill] = it.key; hp_hdl[fill] = it.handle;
          hdl_pos[it.handle] = fill; hdl_live[it.handle] = 1;
          sift_up(fill);
        end
      end
      KIND_POP: begin
        if (fill == 0) r.status = ST_EMPTY;
        else begin
          r.out_handle = hp_hdl[1]; r.out_key = hp_key[1];
          swap_slots(1, fill);
          fill--;
          hdl_live[r.out_handle] = 0;
          if (fill >= 1) sift_down(1);
        end
      end
      default: begin
        if (!hdl_live[it.handle]) r.status = ST_ABSENT;
        else begin
          p = hdl_pos[it.handle];
          if (kind_t'(it.kind) == KIND_REMOVE) begin
            swap_slots(p, fill);
            fill--;
            hdl_live[it.handle] = 0;
            if (p <= fill) begin
              sift_up(p);
              sift_down(p);
            end
          end else begin
            hp_key[p] = it.key;
            sift_up(p);
            sift_down(p);
          end
        end
      end
    endcase
    r.entry_count = fill[8:0];
    r.is_empty = (fill == 0);
    return r;
  endfunction

  // predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) heap_results = {heap_results, heap_apply(in_data)};
      if (out_valid && out_ready) begin
        if (heap_results.size() == 0) begin
          report("unexpected result", 64'(out_data), '0);
        end else begin
          want = heap_results.pop_front();
          if (out_data.status !== want.status)
            report("status", 64'(out_data.status), 64'(want.status));
          if (out_data.out_handle !== want.out_handle)
            report("out_handle", 64'(out_data.out_handle), 64'(want.out_handle));
          if (out_data.out_key !== want.out_key)
            report("out_key", 64'(out_data.out_key), 64'(want.out_key));
          if (out_data.entry_count !== want.entry_count)
            report("entry_count", 64'(out_data.entry_count), 64'(want.entry_count));
          if (out_data.is_empty !== want.is_empty)
            report("is_empty", 64'(out_data.is_empty), 64'(want.is_empty));
        end
      end
    end
    pending_count = heap_results.size();
  end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the indexed min-heap queue
// Drives directed and random push, pop, remove and update traffic with random
// idling on both channels; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module testbench;
  import imhq_pkg::*;

  localparam int RANDOM_OPS = 450;
  localparam int IDLE_LIMIT = 5000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending_count;

  bit        sender_calm;
  bit        receiver_calm;
  bit        hold_off;
  int        quiet_cycles;

  indexed_min_heap_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  imhq_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    sender_calm = 0;
    receiver_calm = 0;
    hold_off = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
  end

  // one transfer on the input channel, with random idle before it
  task automatic send_op(input kind_t k, input logic [7:0] h, input logic [31:0] key);
    while (!sender_calm && $urandom_range(99) < 37) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{kind: k, handle: h, key: key};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // random key: mostly full range, sometimes small to force ties, sometimes extremes
  function automatic logic [31:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stalls, one long hold-off, and calm stretches
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else out_ready <= !hold_off && (receiver_calm || $urandom_range(99) >= 37);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int op_idx;
    int phase;
    @(posedge rst_n);
    @(posedge clk);
    // directed: empty cases, ties, extremes, every kind
    send_op(KIND_POP, 8'd0, 32'd0);
    send_op(KIND_REMOVE, 8'd5, 32'd0);
    send_op(KIND_UPDATE, 8'd5, 32'd1);
    send_op(KIND_PUSH, 8'd255, 32'hFFFF_FFFF);
    send_op(KIND_PUSH, 8'd0, 32'd0);
    send_op(KIND_PUSH, 8'd7, 32'd0);
    send_op(KIND_PUSH, 8'd0, 32'd9);
    send_op(KIND_PUSH, 8'hAA, 32'h5555_5555);
    send_op(KIND_PUSH, 8'h55, 32'hAAAA_AAAA);
    send_op(KIND_UPDATE, 8'd255, 32'd1);
    send_op(KIND_UPDATE, 8'd0, 32'hFFFF_FFFE);
    send_op(KIND_REMOVE, 8'd7, 32'd0);
    send_op(KIND_REMOVE, 8'd7, 32'd0);
    send_op(KIND_POP, 8'd0, 32'd0);
    send_op(KIND_POP, 8'd0, 32'd0);
    send_op(KIND_POP, 8'd0, 32'd0);
    send_op(KIND_POP, 8'd0, 32'd0);
    send_op(KIND_POP, 8'd0, 32'd0);
    send_op(KIND_POP, 8'd0, 32'd0);
    // fill to capacity then push once more, with the receiver held off a while
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int h = 0; h < 256; h++) send_op(KIND_PUSH, h[7:0], pick_key());
        send_op(KIND_PUSH, 8'd3, 32'd1);
      end
    join
    sender_calm = 1;
    receiver_calm = 1;
    for (int n = 0; n < 128; n++) send_op(KIND_POP, 8'd0, 32'd0);
    sender_calm = 0;
    receiver_calm = 0;
    // random: phases biased toward growth or drain, handles from a narrow or wide set
    for (op_idx = 0; op_idx < RANDOM_OPS; op_idx++) begin
      phase = (op_idx / 100) % 3;
      sender_calm = (op_idx >= 200 && op_idx < 300);
      receiver_calm = sender_calm;
      case ($urandom_range(9))
        0, 1, 2: send_op(KIND_PUSH, phase == 0 ? 8'($urandom_range(31)) : 8'($urandom),
                         pick_key());
        3, 4:    send_op(phase == 1 ? KIND_POP : KIND_PUSH, 8'($urandom), pick_key());
        5:       send_op(KIND_POP, 8'($urandom), $urandom);
        6, 7:    send_op(KIND_UPDATE,
                         $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom),
                         pick_key());
        default: send_op(KIND_REMOVE,
                         $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom),
                         $urandom);
      endcase
    end
    in_valid <= 0;
    sender_calm = 0;
    receiver_calm = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
hdl/imhq_pkg.sv
hdl/indexed_min_heap_queue.sv
tb/sv/imhq_checker.sv
tb/sv/testbench.sv
